>>> src/pvc_pkg.sv
package pvc_pkg;

   localparam int unsigned CODE_BYTES = 9;
   localparam int unsigned CODE_W     = 8 * CODE_BYTES;
   localparam int unsigned CNT_W      = 4;
   localparam int unsigned POS_W      = 7;

   // Code length constants; 56 value bits is the most a prefixed code holds
   localparam logic [CNT_W-1:0] LEN_ONE  = 4'd1;
   localparam logic [CNT_W-1:0] LEN_FULL = 4'd9;
   localparam logic [CNT_W-1:0] LEN_ZERO_HEAD = 4'd8;

   typedef struct packed {
      logic        mode;
      logic [7:0]  in_byte;
      logic [63:0] in_value;
   } req_type;

   typedef struct packed {
      logic [7:0]  out_byte;
      logic        byte_valid;
      logic [63:0] out_value;
      logic        value_valid;
      logic        last;
   } rsp_type;

   // One queued job: an encoded byte string or a finished decode
   typedef struct packed {
      logic              is_enc;
      logic [CNT_W-1:0]  nbytes;
      logic [CODE_W-1:0] code;
   } job_type;

   typedef struct packed {
      logic    valid;
      job_type job;
   } push_type;

   typedef struct packed {
      logic    valid;
      job_type job;
   } head_type;

endpackage

>>> src/prefix_varint64_codec_core.sv
// Prefix varint codec for 64-bit unsigned values, little-endian. The first
// byte's trailing zero count plus one is the code length (1..8 bytes); a zero
// first byte means nine bytes. Encode (mode 1) turns one value into 1..9
// result beats, one byte each, the final one flagged by last. Decode (mode 0)
// takes one byte per request beat and returns a single beat with the value
// when the code's final byte arrives; earlier bytes return nothing. An encode
// request drops any partial decode. Rate: a decode byte is taken every cycle
// while the job queue is not full; an encode's bytes leave one per result beat,
// so the single-byte result port sets its pace. A request queue of QUEUE_DEPTH
// jobs lets the front keep accepting while the back drains; a request's job
// passes through a queue entry and then the registered result port.
module prefix_varint64_codec_core #(
   parameter int unsigned QUEUE_DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  pvc_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output pvc_pkg::rsp_type rsp_data
);

   pvc_pkg::push_type push;
   pvc_pkg::head_type head;
   logic              full;
   logic              pop;
   logic              accept;

   // requests are held off only when the job queue is full
   assign req_ready = !full;
   assign accept    = req_valid && req_ready;

   // front: decode state and encode packing, one beat per cycle while not full
   pvc_front u_front (
      .clock  (clock),
      .reset  (reset),
      .accept (accept),
      .req    (req_data),
      .push   (push)
   );

   pvc_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .pop   (pop),
      .full  (full),
      .head  (head)
   );

   // back: serialises a job onto the registered result port
   pvc_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head      (head),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

>>> src/pvc_front.sv
module pvc_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              accept,
   input  pvc_pkg::req_type  req,
   output pvc_pkg::push_type push
);

   logic [pvc_pkg::CNT_W-1:0] left_ff, left_in;
   logic [pvc_pkg::POS_W-1:0] pos_ff, pos_in;
   logic [63:0]               part_ff, part_in;

   logic [63:0]               v;
   logic [pvc_pkg::CNT_W-1:0] enc_n;
   logic [63:0]               enc_word;
   logic [2:0]                tz;
   logic [pvc_pkg::CNT_W-1:0] dec_n;
   logic                      dec_done;

   assign v = req.in_value;

   // encoder length from the highest non-empty 7-bit group; any top-byte bit gives nine
   always_comb begin
      if (|v[63:56])      enc_n = pvc_pkg::LEN_FULL;
      else if (|v[55:49]) enc_n = 4'd8;
      else if (|v[48:42]) enc_n = 4'd7;
      else if (|v[41:35]) enc_n = 4'd6;
      else if (|v[34:28]) enc_n = 4'd5;
      else if (|v[27:21]) enc_n = 4'd4;
      else if (|v[20:14]) enc_n = 4'd3;
      else if (|v[13:7])  enc_n = 4'd2;
      else                enc_n = pvc_pkg::LEN_ONE;
   end

   assign enc_word = (v << enc_n) | (64'd1 << (enc_n - 4'd1));

   // trailing zeros of a non-zero head byte
   always_comb begin
      tz = 3'd7;
      for (int i = 7; i >= 0; i--) begin
         if (req.in_byte[i]) tz = 3'(i);
      end
   end

   assign dec_n = {1'b0, tz} + 4'd1;

   always_comb begin
      left_in = left_ff;
      pos_in  = pos_ff;
      part_in = part_ff;
      if (left_ff == '0) begin
         if (req.in_byte == 8'h00) begin
            part_in = '0;
            pos_in  = '0;
            left_in = pvc_pkg::LEN_ZERO_HEAD;
         end else begin
            part_in = 64'(req.in_byte >> dec_n);
            pos_in  = 7'd8 - {3'b000, dec_n};
            left_in = dec_n - 4'd1;
         end
      end else begin
         part_in = part_ff | (64'(req.in_byte) << pos_ff[5:0]);
         pos_in  = pos_ff + 7'd8;
         left_in = left_ff - 4'd1;
      end
   end

   assign dec_done = (left_in == '0);

   always_comb begin
      push.valid      = accept && (req.mode || dec_done);
      push.job.is_enc = req.mode;
      if (req.mode) begin
         push.job.nbytes = enc_n;
         push.job.code   = (enc_n == pvc_pkg::LEN_FULL) ? {v, 8'h00} : {8'h00, enc_word};
      end else begin
         push.job.nbytes = pvc_pkg::LEN_ONE;
         push.job.code   = {8'h00, part_in};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         left_ff <= '0;
         pos_ff  <= '0;
         part_ff <= '0;
      end else if (accept) begin
         if (req.mode || dec_done) begin
            // encode drops any partial decode; a finished decode clears too
            left_ff <= '0;
            pos_ff  <= '0;
            part_ff <= '0;
         end else begin
            left_ff <= left_in;
            pos_ff  <= pos_in;
            part_ff <= part_in;
         end
      end
   end

endmodule

>>> src/pvc_queue.sv
module pvc_queue #(
   parameter int unsigned DEPTH = 2
) (
   input  logic              clock,
   input  logic              reset,
   input  pvc_pkg::push_type push,
   input  logic              pop,
   output logic              full,
   output pvc_pkg::head_type head
);

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   pvc_pkg::job_type  mem_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ff, wr_in;
   logic [PTR_W-1:0]  rd_ff, rd_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;

   assign full       = (cnt_ff == FULL_CNT);
   assign head.valid = (cnt_ff != '0);
   assign head.job   = mem_ff[rd_ff];

   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (push.valid) wr_in = (wr_ff == LAST_PTR) ? '0 : wr_ff + 1'b1;
      if (pop)        rd_in = (rd_ff == LAST_PTR) ? '0 : rd_ff + 1'b1;
      if (push.valid && !pop)      cnt_in = cnt_ff + 1'b1;
      else if (!push.valid && pop) cnt_in = cnt_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.valid) mem_ff[wr_ff] <= push.job;
   end

endmodule

>>> src/pvc_back.sv
module pvc_back (
   input  logic              clock,
   input  logic              reset,
   input  pvc_pkg::head_type head,
   output logic              pop,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output pvc_pkg::rsp_type  rsp_data
);

   logic [pvc_pkg::CNT_W-1:0]               idx_ff, idx_in;
   logic                                    vld_ff;
   pvc_pkg::rsp_type                        rsp_ff, rsp_in;
   logic [pvc_pkg::CODE_BYTES-1:0][7:0]     code_bytes;
   logic                                    load;
   logic                                    final_beat;

   assign code_bytes = head.job.code;
   assign load       = head.valid && (!vld_ff || rsp_ready);
   assign final_beat = !head.job.is_enc || (idx_ff == head.job.nbytes - 4'd1);
   assign pop        = load && final_beat;

   always_comb begin
      if (head.job.is_enc) begin
         rsp_in.out_byte    = code_bytes[idx_ff];
         rsp_in.byte_valid  = 1'b1;
         rsp_in.out_value   = '0;
         rsp_in.value_valid = 1'b0;
      end else begin
         rsp_in.out_byte    = '0;
         rsp_in.byte_valid  = 1'b0;
         rsp_in.out_value   = head.job.code[63:0];
         rsp_in.value_valid = 1'b1;
      end
      rsp_in.last = final_beat;
      idx_in      = final_beat ? '0 : idx_ff + 4'd1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
         idx_ff <= '0;
      end else begin
         if (load) begin
            vld_ff <= 1'b1;
            idx_ff <= idx_in;
         end else if (rsp_ready) begin
            vld_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) rsp_ff <= rsp_in;
   end

   assign rsp_valid = vld_ff;
   assign rsp_data  = rsp_ff;

endmodule

>>> src/pvc_checker.sv
module pvc_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input pvc_pkg::req_type req_data,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input pvc_pkg::rsp_type rsp_data
);

   // stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result beat changed under stall");

   // every beat is either a byte or a value, never both
   a_one_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.byte_valid != rsp_data.value_valid)
      else $error("result beat kind ambiguous");

   a_value_beat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.value_valid |-> rsp_data.last && rsp_data.out_byte == 8'h00)
      else $error("decode beat malformed");

   a_byte_beat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.byte_valid |-> rsp_data.out_value == 64'd0)
      else $error("encode beat carries a value");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind prefix_varint64_codec_core pvc_checker u_pvc_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

>>> test/varint_codec_checker.sv
module varint_codec_checker (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_ready,
   input  pvc_pkg::req_type req_data,
   input  logic             rsp_valid,
   input  logic             rsp_ready,
   input  pvc_pkg::rsp_type rsp_data,
   output int               fail_count,
   output int               outstanding
);
   timeunit 1ns;
   timeprecision 1ps;

   // decoder state as the block should hold it
   logic [3:0]  dec_remaining;
   logic [63:0] dec_acc;
   logic [6:0]  dec_shift;

   pvc_pkg::rsp_type due_rsp[$];
   int               errors = 0;

   function automatic pvc_pkg::rsp_type byte_beat(logic [7:0] b, logic is_last);
      pvc_pkg::rsp_type r;
      r            = '0;
      r.out_byte   = b;
      r.byte_valid = 1'b1;
      r.last       = is_last;
      return r;
   endfunction

   task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         errors++;
      end
   endtask

   task automatic predict_codec(pvc_pkg::req_type item);
      int               nbits;
      int               len;
      logic [63:0]      word;
      pvc_pkg::rsp_type r;
      if (item.mode) begin
         // encode drops any partial decode
         dec_remaining = '0;
         dec_acc       = '0;
         dec_shift     = '0;
         nbits         = 0;
         for (int i = 0; i < 64; i++) begin
            if (item.in_value[i]) nbits = i + 1;
         end
         if (nbits > 56) begin
            due_rsp.push_back(byte_beat(8'h00, 1'b0));
            for (int k = 0; k < 8; k++) begin
               due_rsp.push_back(byte_beat(item.in_value[8*k +: 8], k == 7));
            end
         end else begin
            len  = (nbits == 0) ? 1 : (nbits + 6) / 7;
            word = (item.in_value << len) | (64'd1 << (len - 1));
            for (int k = 0; k < len; k++) begin
               due_rsp.push_back(byte_beat(word[8*k +: 8], k == len - 1));
            end
         end
      end else begin
         if (dec_remaining == 0) begin
            if (item.in_byte == 8'h00) begin
               dec_acc       = '0;
               dec_shift     = '0;
               dec_remaining = 4'd8;
            end else begin
               len = 1;
               while (!item.in_byte[len-1]) len++;
               dec_acc       = 64'(item.in_byte >> len);
               dec_shift     = 7'(8 - len);
               dec_remaining = 4'(len - 1);
            end
         end else begin
            dec_acc       = dec_acc | (64'(item.in_byte) << dec_shift[5:0]);
            dec_shift     = dec_shift + 7'd8;
            dec_remaining = dec_remaining - 4'd1;
         end
         if (dec_remaining == 0) begin
            r             = '0;
            r.out_value   = dec_acc;
            r.value_valid = 1'b1;
            r.last        = 1'b1;
            due_rsp.push_back(r);
            dec_acc   = '0;
            dec_shift = '0;
         end
      end
   endtask

   always @(posedge clock) begin
      pvc_pkg::rsp_type want;
      if (reset) begin
         dec_remaining = '0;
         dec_acc       = '0;
         dec_shift     = '0;
         due_rsp.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (due_rsp.size() == 0) begin
               $error("result beat with nothing expected: %p", rsp_data);
               errors++;
            end else begin
               want = due_rsp.pop_front();
               check_field("out_byte", 64'(want.out_byte), 64'(rsp_data.out_byte));
               check_field("byte_valid", 64'(want.byte_valid), 64'(rsp_data.byte_valid));
               check_field("out_value", want.out_value, rsp_data.out_value);
               check_field("value_valid", 64'(want.value_valid),
                           64'(rsp_data.value_valid));
               check_field("last", 64'(want.last), 64'(rsp_data.last));
            end
         end
         if (req_valid && req_ready) predict_codec(req_data);
      end
      fail_count  <= errors;
      outstanding <= due_rsp.size();
   end

endmodule

>>> test/testbench.sv
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   // generous: every beat waiting out long receiver stalls, nine bytes per item
   localparam int CYCLE_LIMIT  = 200000;
   localparam int PHASE_ITEMS  = 32;
   localparam int TAIL_CYCLES  = 16;

   logic             clock     = 1'b0;
   logic             reset     = 1'b1;
   logic             req_valid = 1'b0;
   pvc_pkg::req_type req_data  = '0;
   logic             rsp_ready = 1'b0;
   logic             req_ready;
   logic             rsp_valid;
   pvc_pkg::rsp_type rsp_data;

   int fail_count;
   int outstanding;
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int items_sent    = 0;
   int cycles        = 0;

   always #5 clock = ~clock;

   prefix_varint64_codec_core DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   varint_codec_checker checker_inst (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .fail_count  (fail_count),
      .outstanding (outstanding)
   );

   // Receiver: one decision per edge, so ready never gets two updates in a step
   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
   end

   // Watchdog
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   // Random value with a random number of significant bits, so every code
   // length turns up; a zero shift keeps the top bits in play.
   function automatic logic [63:0] spread_value();
      return {$urandom, $urandom} >> $urandom_range(0, 63);
   endfunction

   // Offer one request beat and hold it until taken. Gaps lower valid first,
   // so valid is never dropped and raised within one step.
   task automatic send_beat(pvc_pkg::req_type item);
      if ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(0, 99) < send_idle_pct);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (!req_ready);
      items_sent++;
   endtask

   task automatic encode_value(logic [63:0] v);
      pvc_pkg::req_type item;
      item.mode     = 1'b1;
      item.in_byte  = 8'($urandom);   // ignored on encode, kept noisy
      item.in_value = v;
      send_beat(item);
   endtask

   task automatic decode_byte(logic [7:0] b);
      pvc_pkg::req_type item;
      item.mode     = 1'b0;
      item.in_byte  = b;
      item.in_value = {$urandom, $urandom};   // ignored on decode
      send_beat(item);
   endtask

   // Feed the first nsend bytes of a len-byte code for v. A length longer
   // than v needs gives a non-shortest code; nsend < len breaks it off.
   task automatic decode_code(logic [63:0] v, int len, int nsend);
      logic [71:0] code;
      logic [63:0] word;
      if (len == 9) begin
         code = {v, 8'h00};
      end else begin
         word = ((v & ((64'd1 << (7 * len)) - 64'd1)) << len) | (64'd1 << (len - 1));
         code = 72'(word);
      end
      for (int k = 0; k < nsend; k++) begin
         decode_byte(code[8*k +: 8]);
      end
   endtask

   // Stop offering and let every expected result come back. The first edge
   // lets the checker's count settle after the last accepted beat.
   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
   endtask

   // Random stretch: whole codes with random content and slightly fewer encodes,
   // and a share of noise bytes and codes cut short by an encode.
   task automatic random_phase(int count);
      int stop_at;
      int pick;
      int len;
      stop_at = items_sent + count;
      while (items_sent < stop_at) begin
         pick = $urandom_range(0, 99);
         if (pick < 40) begin
            encode_value(spread_value());
         end else if (pick < 85) begin
            len = $urandom_range(1, 9);
            decode_code(spread_value(), len, len);
         end else if ($urandom_range(0, 1) == 0) begin
            decode_byte(8'($urandom));
         end else begin
            len = $urandom_range(2, 9);
            decode_code(spread_value(), len, $urandom_range(1, len - 1));
            encode_value(spread_value());
         end
      end
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Phase one: sender mostly keen, receiver stalling about half the time
      send_idle_pct = 13;
      recv_idle_pct = 53;

      // Directed: code length edges on encode
      encode_value(64'd0);
      encode_value(64'd127);
      encode_value(64'd128);
      encode_value(64'h00FF_FFFF_FFFF_FFFF);   // widest eight-byte code
      encode_value(64'h0100_0000_0000_0000);   // first nine-byte value
      // Directed decodes: single byte, zero head, 0x80 head (non-shortest)
      decode_byte(8'h01);
      decode_code(64'hFFFF_FFFF_FFFF_FFFF, 9, 9);
      decode_code(64'd5, 8, 8);
      // Partial decode dropped by an encode of the largest value
      decode_code(64'h1234, 3, 1);
      encode_value(64'hFFFF_FFFF_FFFF_FFFF);

      random_phase(PHASE_ITEMS);

      // Hold off until the block has handed back everything owed
      wait_drained();

      // Phase two: the roles swapped
      send_idle_pct = 53;
      recv_idle_pct = 13;
      random_phase(PHASE_ITEMS);

      // Phase three: back to back on both sides
      send_idle_pct = 0;
      recv_idle_pct = 0;
      random_phase(PHASE_ITEMS);

      wait_drained();
      repeat (TAIL_CYCLES) @(posedge clock);

      if (fail_count == 0 && outstanding == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
